/* rtl/core/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int DEPTH = 32;
  localparam int EW    = 8;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_ALTER  = 3'd2,
    OP_LOCATE = 3'd3,
    OP_GET    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Per-cycle action broadcast to every slot cell
  typedef enum logic [2:0] {
    CK_HOLD = 3'd0,
    CK_PUT  = 3'd1,
    CK_INS  = 3'd2,
    CK_DEL  = 3'd3,
    CK_CLR  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          kind;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [EW-1:0]     value;
  } ile_ctl_t;

endpackage

/* rtl/core/indexed_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Fixed-capacity ordered list kept in a row of slot cells.
// ----------------------------------------------------------------------------
//  channel  | ports              | payload
//  ---------+--------------------+------------------------------------------
//  command  | in_tvalid/tready   | operation, index, value
//  result   | out_tvalid/tready  | status, position, read_data, fill_count
//  config   | cfg_wr_en          | capacity
//
//  A command transfer loads the command register; the result is then registered
//  in the output register. Locate first waits for the registered per-cell match
//  vector before the first-hit encode. One command is in flight at a time, so a
//  new command is taken only after the current one has issued its result; the
//  next one is taken while a result waits in the output register. A stalled
//  result holds the cell row. Reset clears every slot, the fill count and sets
//  capacity to 32.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit import ile_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // operation[2:0], index[7:3], value[15:8]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // status[2:0], position[7:3],
                                       // read_data[15:8], fill_count[21:16]
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  ile_ctl_t                 ctl;
  logic [DEPTH-1:0][EW-1:0] slot_data;
  logic [DEPTH-1:0]         slot_match;
  logic [ST_W-1:0]          status;
  logic [IDX_W-1:0]         position;
  logic [EW-1:0]            read_data;
  logic [CNT_W-1:0]         fill_count;

  ile_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_op          (in_tdata[2:0]),
    .in_idx         (in_tdata[7:3]),
    .in_value       (in_tdata[15:8]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .slot_data      (slot_data),
    .slot_match     (slot_match),
    .ctl            (ctl),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (status),
    .out_position   (position),
    .out_read_data  (read_data),
    .out_fill_count (fill_count)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = slot_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = slot_data[g+1];
    end
    ile_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (slot_data[g]),
      .match      (slot_match[g])
    );
  end

  assign out_tdata = {2'b00, fill_count, read_data, position, status};

endmodule

/* rtl/core/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element, shifts from either neighbor, compares.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  ile_ctl_t         ctl,
  input  logic [EW-1:0]    left_data,
  input  logic [EW-1:0]    right_data,
  output logic [EW-1:0]    data,
  output logic             match
);

  logic [EW-1:0]    data_r;
  logic [EW-1:0]    data_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] pos_ext;

  assign idx_ext = {1'b0, cell_idx};
  assign idx_inc = idx_ext + CNT_W'(1);
  assign pos_ext = {1'b0, ctl.pos};

  always_comb begin
    data_nxt = data_r;
    case (ctl.kind)
      CK_PUT: begin
        if (cell_idx == ctl.pos) data_nxt = ctl.value;
      end
      CK_INS: begin
        if (cell_idx == ctl.pos) begin
          data_nxt = ctl.value;
        end else if (idx_ext > pos_ext && idx_ext <= ctl.count) begin
          data_nxt = left_data;
        end
      end
      CK_DEL: begin
        // drop the vacated tail slot, pull the rest left
        if (idx_inc == ctl.count) begin
          data_nxt = '0;
        end else if (idx_ext >= pos_ext && idx_inc < ctl.count) begin
          data_nxt = right_data;
        end
      end
      CK_CLR:  data_nxt = '0;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data  = data_r;
  assign match = (data_r == ctl.value) && (idx_ext < ctl.count);

endmodule

/* rtl/core/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// ile_ctrl
// Command sequencer: holds the command, fill count and capacity, drives the
// cell row and builds the result.
// ----------------------------------------------------------------------------
module ile_ctrl import ile_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [OP_W-1:0]            in_op,
  input  logic [IDX_W-1:0]           in_idx,
  input  logic [EW-1:0]              in_value,
  input  logic                       cfg_wr_en,
  input  logic [CNT_W-1:0]           cfg_wr_data,
  input  logic [DEPTH-1:0][EW-1:0]   slot_data,
  input  logic [DEPTH-1:0]           slot_match,
  output ile_ctl_t                   ctl,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ST_W-1:0]            out_status,
  output logic [IDX_W-1:0]           out_position,
  output logic [EW-1:0]              out_read_data,
  output logic [CNT_W-1:0]           out_fill_count
);

  logic             cmd_valid_r;
  logic [OP_W-1:0]  cmd_op_r;
  logic [IDX_W-1:0] cmd_idx_r;
  logic [EW-1:0]    cmd_value_r;
  logic             match_ok_r;
  logic [DEPTH-1:0] match_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;
  logic             out_valid_r;
  logic [ST_W-1:0]  status_r;
  logic [IDX_W-1:0] position_r;
  logic [EW-1:0]    read_data_r;

  logic             out_free;
  logic             fire;
  logic [CNT_W-1:0] idx_ext;
  logic             found;
  logic [IDX_W-1:0] first_pos;
  status_t          status_nxt;
  logic [IDX_W-1:0] position_nxt;
  logic [EW-1:0]    read_data_nxt;
  cell_op_t         kind;
  logic [IDX_W-1:0] pos;

  assign cap_eff = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) :
                   (cap_r == '0) ? CNT_W'(1) : cap_r;
  assign idx_ext  = {1'b0, cmd_idx_r};
  assign out_free = !out_valid_r || out_tready;
  // locate waits for the registered match vector
  assign fire = cmd_valid_r && out_free &&
                ((cmd_op_r != OP_LOCATE) || match_ok_r);
  assign in_tready = !cmd_valid_r;

  always_comb begin
    found     = |match_r;
    first_pos = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match_r[k]) first_pos = IDX_W'(k);
    end
  end

  always_comb begin
    status_nxt    = ST_OK;
    position_nxt  = '0;
    read_data_nxt = '0;
    count_nxt     = count_r;
    kind          = CK_HOLD;
    pos           = '0;
    case (cmd_op_r)
      OP_INSERT: begin
        if (idx_ext >= cap_eff) begin
          status_nxt = ST_RANGE;
        end else if (count_r >= cap_eff) begin
          status_nxt = ST_FULL;
        end else begin
          kind      = CK_INS;
          pos       = (idx_ext >= count_r) ? count_r[IDX_W-1:0] : cmd_idx_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (idx_ext >= cap_eff) begin
          status_nxt = ST_RANGE;
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          kind      = CK_DEL;
          count_nxt = count_r - CNT_W'(1);
          pos       = (idx_ext >= count_r) ? count_nxt[IDX_W-1:0] : cmd_idx_r;
        end
      end
      OP_ALTER: begin
        if (idx_ext >= cap_eff) begin
          status_nxt = ST_RANGE;
        end else if (idx_ext < count_r) begin
          kind = CK_PUT;
          pos  = cmd_idx_r;
        end else if (count_r >= cap_eff) begin
          status_nxt = ST_FULL;
        end else begin
          kind      = CK_PUT;
          pos       = count_r[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_LOCATE: begin
        if (found) begin
          position_nxt = first_pos;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      OP_GET: begin
        if (idx_ext >= cap_eff) begin
          status_nxt = ST_RANGE;
        end else begin
          read_data_nxt = slot_data[cmd_idx_r];
        end
      end
      OP_CLEAR: begin
        kind      = CK_CLR;
        count_nxt = '0;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_comb begin
    ctl.kind  = fire ? kind : CK_HOLD;
    ctl.pos   = pos;
    ctl.count = count_r;
    ctl.value = cmd_value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      match_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        cmd_valid_r <= 1'b1;
      end else if (fire) begin
        cmd_valid_r <= 1'b0;
      end
      match_ok_r <= cmd_valid_r && !fire;
      if (fire) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_r <= slot_match;
    if (in_tvalid && in_tready) begin
      cmd_op_r    <= in_op;
      cmd_idx_r   <= in_idx;
      cmd_value_r <= in_value;
    end
    if (fire) begin
      status_r    <= status_nxt;
      position_r  <= position_nxt;
      read_data_r <= read_data_nxt;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = status_r;
  assign out_position   = position_r;
  assign out_read_data  = read_data_r;
  assign out_fill_count = count_r;

endmodule

/* rtl/core/ile_checker.sv */
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the list engine's result stream.
// ----------------------------------------------------------------------------
module ile_checker import ile_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [23:0]      out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:16] <= CNT_W'(DEPTH))
    else $error("fill count above store depth");

  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:3] != '0 |-> out_tdata[2:0] == ST_OK)
    else $error("position reported with error status");

  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:8] != '0 |-> out_tdata[2:0] == ST_OK)
    else $error("read data reported with error status");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_EMPTY |-> out_tdata[21:16] == '0)
    else $error("empty status with nonzero fill count");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (.*);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed list engine against a cycle-free list predictor kept in
// step with every accepted command. Directed tests walk the empty, full,
// out-of-range and capacity corner cases, then random traffic runs under
// several capacity settings with bursty commands and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import ile_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] pos;
    logic [EW-1:0]    rd;
    logic [CNT_W-1:0] fill;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;   // operation[2:0], index[7:3], value[15:8]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [23:0]      out_tdata;  // status[2:0], position[7:3],
                                // read_data[15:8], fill_count[21:16]
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  // predicted list contents
  logic [EW-1:0]    list_mem [DEPTH];
  int               list_fill;
  logic [CNT_W-1:0] list_cap;

  list_result_t     pending_replies [$];
  int               error_count;
  int               cmd_count;
  int               reply_count;
  int               cap_writes;
  int               status_seen [5];
  int               burst_left;
  int               idle_cycles;

  indexed_list_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_capacity();
    int ec;
    ec = int'(list_cap);
    if (ec > DEPTH) ec = DEPTH;
    if (ec == 0) ec = 1;
    return ec;
  endfunction

  function automatic void apply_command(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [EW-1:0] val,
                                        output list_result_t res);
    int ec;
    int ix;
    int j;
    ec = eff_capacity();
    ix = int'(idx);
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (ix >= ec) res.status = ST_RANGE;
        else if (list_fill >= ec) res.status = ST_FULL;
        else begin
          if (ix >= list_fill) begin
            list_mem[list_fill] = val;
          end else begin
            for (j = list_fill; j > ix; j--) list_mem[j] = list_mem[j-1];
            list_mem[ix] = val;
          end
          list_fill++;
        end
      end
      OP_DELETE: begin
        if (ix >= ec) res.status = ST_RANGE;
        else if (list_fill == 0) res.status = ST_EMPTY;
        else begin
          // an index past the end removes the last element
          for (j = ix; j + 1 < list_fill; j++) list_mem[j] = list_mem[j+1];
          list_mem[list_fill-1] = '0;
          list_fill--;
        end
      end
      OP_ALTER: begin
        if (ix >= ec) res.status = ST_RANGE;
        else if (ix < list_fill) list_mem[ix] = val;
        else if (list_fill >= ec) res.status = ST_FULL;
        else begin
          list_mem[list_fill] = val;
          list_fill++;
        end
      end
      OP_LOCATE: begin
        res.status = ST_NOTFOUND;
        for (j = 0; j < list_fill; j++) begin
          if (list_mem[j] == val) begin
            res.status = ST_OK;
            res.pos = IDX_W'(j);
            break;
          end
        end
      end
      OP_GET: begin
        if (ix >= ec) res.status = ST_RANGE;
        else res.rd = list_mem[ix];
      end
      OP_CLEAR: begin
        for (j = 0; j < DEPTH; j++) list_mem[j] = '0;
        list_fill = 0;
      end
      default: ;
    endcase
    res.fill = CNT_W'(list_fill);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
             reply_count, field, got, want);
    error_count++;
  endtask

  // one command transfer, then drop valid and idle between bursts
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [EW-1:0] val);
    list_result_t res;
    in_tdata  = {val, idx, op};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_command(op, idx, val, res);
    pending_replies.push_back(res);
    status_seen[res.status]++;
    cmd_count++;
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left--;
    if (burst_left <= 0) begin
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20)
                                               : $urandom_range(8, 1);
    end
  endtask

  task automatic wait_replies_drained();
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    wait_replies_drained();
    cfg_wr_data = cap;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    list_cap    = cap;
    cap_writes++;
  endtask

  task automatic test_empty_list();
    send_cmd(OP_GET, 5'd31, 8'h00);     // beyond fill reads zero
    send_cmd(OP_LOCATE, 5'd0, 8'h00);   // empty list never matches
    send_cmd(OP_DELETE, 5'd0, 8'hFF);
    send_cmd(OP_SPARE_LO, 5'd31, 8'hFF);
    send_cmd(OP_SPARE_HI, 5'd0, 8'h00);
  endtask

  task automatic test_small_capacity();
    set_capacity(6'd3);
    send_cmd(OP_INSERT, 5'd31, 8'h12);  // index outside capacity
    send_cmd(OP_INSERT, 5'd2, 8'hFF);   // append
    send_cmd(OP_INSERT, 5'd0, 8'h00);   // shift right
    send_cmd(OP_ALTER, 5'd2, 8'h5A);    // append through alter
    send_cmd(OP_INSERT, 5'd1, 8'h11);   // full
    send_cmd(OP_LOCATE, 5'd0, 8'hFF);
    send_cmd(OP_LOCATE, 5'd0, 8'h77);
    send_cmd(OP_GET, 5'd2, 8'h00);
    send_cmd(OP_DELETE, 5'd2, 8'h00);
    send_cmd(OP_DELETE, 5'd0, 8'h00);
    send_cmd(OP_GET, 5'd1, 8'h00);      // vacated slot is zero
  endtask

  task automatic test_capacity_limits();
    set_capacity(6'd0);                 // behaves as one slot
    send_cmd(OP_INSERT, 5'd0, 8'h33);
    send_cmd(OP_GET, 5'd1, 8'h00);
    send_cmd(OP_DELETE, 5'd0, 8'h00);
    set_capacity(6'd63);                // clamps to the store depth
    send_cmd(OP_INSERT, 5'd31, 8'hC3);
    send_cmd(OP_DELETE, 5'd30, 8'h00);  // past end removes the last one
    send_cmd(OP_CLEAR, 5'd0, 8'h00);
  endtask

  task automatic test_capacity_shrink();
    int k;
    for (k = 0; k < 4; k++) send_cmd(OP_INSERT, 5'd31, EW'(8'h40 + k));
    set_capacity(6'd2);                 // contents survive the shrink
    send_cmd(OP_INSERT, 5'd0, 8'h99);
    send_cmd(OP_ALTER, 5'd1, 8'hA5);
    send_cmd(OP_DELETE, 5'd1, 8'h00);
    send_cmd(OP_GET, 5'd3, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] caps [6] = '{6'd32, 6'd5, 6'd63, 6'd1, 6'd0, 6'd17};
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [EW-1:0]    val;
    int p;
    int n;
    int r;
    int ec;
    for (p = 0; p < 7; p++) begin
      set_capacity((p < 6) ? caps[p] : CNT_W'($urandom_range(63, 0)));
      for (n = 0; n < 72; n++) begin
        ec  = eff_capacity();
        r   = $urandom_range(99, 0);
        idx = ($urandom_range(6, 0) == 0) ? IDX_W'($urandom_range(31, 0))
                                          : IDX_W'($urandom_range(ec - 1, 0));
        val = ($urandom_range(3, 0) == 0) ? EW'($urandom_range(255, 0))
                                          : EW'($urandom_range(31, 0));
        if (r < 30) op = OP_INSERT;
        else if (r < 45) op = OP_DELETE;
        else if (r < 60) op = OP_ALTER;
        else if (r < 75) op = OP_LOCATE;
        else if (r < 90) op = OP_GET;
        else if (r < 93) op = OP_CLEAR;
        else if (r < 95) op = r[0] ? OP_SPARE_LO : OP_SPARE_HI;
        else op = OP_W'($urandom_range(7, 0));
        // aim most lookups at a value that is present
        if (op == OP_LOCATE && list_fill > 0 && $urandom_range(9, 0) < 7)
          val = list_mem[$urandom_range(list_fill - 1, 0)];
        send_cmd(op, idx, val);
      end
    end
  endtask

  // receiver: switch between stall patterns at random intervals
  int rx_mode;
  int rx_left;
  int rx_tick;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_left    <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(3, 0);
        rx_left <= $urandom_range(60, 10);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(1, 0);
        2: out_tready <= ($urandom_range(3, 0) == 0);
        default: out_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_replies
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata, 0);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[2:0] != want.status)
          report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[7:3] != want.pos)
          report_mismatch("position", out_tdata[7:3], want.pos);
        if (out_tdata[15:8] != want.rd)
          report_mismatch("read_data", out_tdata[15:8], want.rd);
        if (out_tdata[21:16] != want.fill)
          report_mismatch("fill_count", out_tdata[21:16], want.fill);
      end
    end
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int k;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rx_mode     = 0;
    rx_tick     = 0;
    idle_cycles = 0;
    burst_left  = 1;
    for (k = 0; k < DEPTH; k++) list_mem[k] = '0;
    for (k = 0; k < 5; k++) status_seen[k] = 0;
    list_fill   = 0;
    list_cap    = 6'd32;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_list();
    test_small_capacity();
    test_capacity_limits();
    test_capacity_shrink();
    test_random_traffic();

    wait_replies_drained();
    repeat (6) @(negedge clk);
    if (pending_replies.size() != 0)
      report_mismatch("results never arrived", 0, pending_replies.size());

    $display("Sent %0d list commands, checked %0d results across %0d capacity writes",
             cmd_count, reply_count, cap_writes);
    $display("Outcomes: ok %0d, bad index %0d, full %0d, empty %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_NOTFOUND]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/ile_ctrl.sv
rtl/core/indexed_list_engine_unit.sv
rtl/core/ile_checker.sv
tb/sv/testbench.sv
